FILE: design/bias_gelu_forward_backward_assert.svh
// ----------------------------------------------------------------------------
// bias_gelu_forward_backward_assert.svh
// Assertion macros used by the checker file of the GELU unit.
// ----------------------------------------------------------------------------
`ifndef BIAS_GELU_FORWARD_BACKWARD_ASSERT_SVH
`define BIAS_GELU_FORWARD_BACKWARD_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BGFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define BGFB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/bgfb_pkg.sv
// ----------------------------------------------------------------------------
// bgfb_pkg
// Types, constants, lookup table and fixed-point helpers for the GELU unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgfb_pkg;

  localparam int DataWidth   = 16;
  localparam int FracBits    = 10;
  localparam int TanhDepth   = 256;
  localparam int TanhAbits   = $clog2(TanhDepth);
  localparam int TanhFbits   = FracBits + 2 - TanhAbits;
  localparam int PipeLatency = 12;

  localparam logic signed [31:0] KSqrt = 32'sd856722024;
  localparam logic signed [31:0] KCube = 32'sd48012366;
  localparam logic [31:0]        Q30One = 32'd1 << 30;
  localparam logic signed [31:0] OneQ  = 32'sd1 <<< FracBits;

  // Register map
  localparam logic [2:0] RegBiasEnable = 3'd0;

  typedef struct packed {
    logic                        mode;
    logic signed [DataWidth-1:0] activation_in;
    logic signed [DataWidth-1:0] bias_value;
    logic signed [DataWidth-1:0] grad_in;
  } bgfb_req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic                        saturated;
  } bgfb_res_t;

  // Side-band context that travels with each request down the pipe
  typedef struct packed {
    logic               vld;
    logic               mode;
    logic               sat;
    logic signed [15:0] x;
    logic signed [15:0] g;
    logic signed [14:0] xc;
    logic signed [14:0] kxs;
    logic signed [12:0] x2m;
  } bgfb_ctx_t;

  typedef logic [31:0] tanh_lut_t [TanhDepth];

  // Product a*b / 2^k, rounded to nearest, ties away from zero.
  function automatic logic signed [63:0] rmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input int unsigned k);
    logic        neg;
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] p;
    neg = a[31] ^ b[31];
    ua  = a[31] ? 32'(-a) : 32'(a);
    ub  = b[31] ? 32'(-b) : 32'(b);
    p   = ({32'd0, ua} * {32'd0, ub} + (64'd1 << (k - 1))) >> k;
    rmul = neg ? -$signed(p) : $signed(p);
  endfunction

  // Clamp to the data range; bit 16 flags a clamp.
  function automatic logic [16:0] clamp16(input logic signed [31:0] v);
    logic [16:0] r;
    if (v > 32'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -32'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    clamp16 = r;
  endfunction

  // tanh(4i/depth) in Q30, integer series plus repeated squaring
  function automatic logic [31:0] tanh_entry(input int unsigned i);
    logic [63:0] one;
    logic [63:0] y;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    one = 64'd1 << 30;
    y   = ((64'(i) * 64'd8) << 30) >> (TanhAbits + 8);
    t1  = (one * y) >> 30;
    t2  = ((t1 * y) >> 30) >> 1;
    t3  = ((t2 * y) >> 30) / 3;
    t4  = ((t3 * y) >> 30) >> 2;
    e   = one - t1 + t2 - t3 + t4;
    for (int k = 0; k < 8; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    // restoring long division of (one-e)<<30 by (one+e)
    num = (one - e) << 30;
    den = one + e;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    tanh_entry = quo[31:0];
  endfunction

  function automatic tanh_lut_t build_lut();
    tanh_lut_t t;
    for (int i = 0; i < TanhDepth; i++) begin
      t[i] = tanh_entry(i);
    end
    build_lut = t;
  endfunction

  localparam tanh_lut_t TanhLut = build_lut();

endpackage

FILE: design/bias_gelu_forward_backward.sv
// ----------------------------------------------------------------------------
// bias_gelu_forward_backward
// Elementwise GELU (tanh form) forward and backward in signed Q5.10.
// ----------------------------------------------------------------------------
// A request is taken at every rising edge at which start is high and busy is
// low; busy is low whenever the block is out of reset, so one element per
// clock streams through. Each request passes twelve register stages (bias
// add, cubic argument, table tanh, derivative chain, output register): its
// result sits on out_data with out_valid high for exactly one cycle. The
// result is not held; the receiver must take it in that cycle.
// bias_enable sits at byte address 0 of the configuration port and resets
// to 1.
`timescale 1ns / 1ps

module bias_gelu_forward_backward (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bgfb_pkg::bgfb_req_t in_data,
  output logic                out_valid,
  output bgfb_pkg::bgfb_res_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bgfb_pkg::*;

  logic               bias_en_r;
  logic               bias_en_nxt;
  logic               wr_en;
  bgfb_ctx_t          ctx_p, ctx_t;
  logic signed [15:0] u;
  logic signed [11:0] t;

  // Register write and read back
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    bias_en_nxt = bias_en_r;
    if (wr_en && (paddr == RegBiasEnable)) begin
      bias_en_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_en_r <= 1'b1;
    end else begin
      bias_en_r <= bias_en_nxt;
    end
  end

  assign prdata = (paddr == RegBiasEnable) ? {31'd0, bias_en_r} : 32'd0;
  assign busy   = ~rst_n;

  bgfb_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (start & ~busy),
    .req     (in_data),
    .bias_en (bias_en_r),
    .ctx     (ctx_p),
    .u       (u)
  );

  bgfb_tanh u_tanh (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctx_in (ctx_p),
    .u      (u),
    .ctx    (ctx_t),
    .t      (t)
  );

  bgfb_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctx_in  (ctx_t),
    .t       (t),
    .res_vld (out_valid),
    .res     (out_data)
  );

endmodule

FILE: design/bgfb_poly.sv
// ----------------------------------------------------------------------------
// bgfb_poly
// Bias add and the cubic argument u = s*(x + c*x^3), five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgfb_poly (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_vld,
  input  bgfb_pkg::bgfb_req_t req,
  input  logic                bias_en,
  output bgfb_pkg::bgfb_ctx_t ctx,
  output logic signed [15:0]  u
);
  import bgfb_pkg::*;

  bgfb_ctx_t c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt, c4_r, c4_nxt;
  logic [16:0]        sq_r, sq_nxt;
  logic signed [15:0] m1_r, m1_nxt;
  logic signed [15:0] u_r, u_nxt;
  logic signed [16:0] bsum;
  logic [16:0]        bclamp;
  logic signed [14:0] xc;
  logic signed [16:0] xsum;

  // Add bias and clamp to range
  always_comb begin
    bsum = 17'(req.activation_in) + (bias_en ? 17'(req.bias_value) : 17'sd0);
    bclamp = clamp16(32'(bsum));
    c0_nxt = '0;
    c0_nxt.vld  = req_vld;
    c0_nxt.mode = req.mode;
    c0_nxt.sat  = bclamp[16];
    c0_nxt.x    = $signed(bclamp[15:0]);
    c0_nxt.g    = req.grad_in;
  end

  // Limit x for the polynomial, square it, scale by s
  always_comb begin
    if (c0_r.x > 16'sd8192) begin
      xc = 15'sd8192;
    end else if (c0_r.x < -16'sd8192) begin
      xc = -15'sd8192;
    end else begin
      xc = 15'(c0_r.x);
    end
    c1_nxt     = c0_r;
    c1_nxt.xc  = xc;
    c1_nxt.kxs = 15'(rmul(32'(xc), KSqrt, 30));
    sq_nxt     = 17'(rmul(32'(xc), 32'(xc), FracBits));
  end

  // x^2 times c
  always_comb begin
    c2_nxt     = c1_r;
    c2_nxt.x2m = 13'(rmul(32'($signed({1'b0, sq_r})), KCube, 30));
  end

  // x times c*x^2
  always_comb begin
    c3_nxt = c2_r;
    m1_nxt = 16'(rmul(32'(c2_r.xc), 32'(c2_r.x2m), FracBits));
  end

  // Scale the sum by s
  always_comb begin
    c4_nxt = c3_r;
    xsum   = 17'(c3_r.xc) + 17'(m1_r);
    u_nxt  = 16'(rmul(32'(xsum), KSqrt, 30));
  end

  // Advance the valid bits (reset) and the data (no reset)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r.vld <= 1'b0;
      c1_r.vld <= 1'b0;
      c2_r.vld <= 1'b0;
      c3_r.vld <= 1'b0;
      c4_r.vld <= 1'b0;
    end else begin
      c0_r.vld <= c0_nxt.vld;
      c1_r.vld <= c1_nxt.vld;
      c2_r.vld <= c2_nxt.vld;
      c3_r.vld <= c3_nxt.vld;
      c4_r.vld <= c4_nxt.vld;
    end
    c0_r[$bits(bgfb_ctx_t)-2:0] <= c0_nxt[$bits(bgfb_ctx_t)-2:0];
    c1_r[$bits(bgfb_ctx_t)-2:0] <= c1_nxt[$bits(bgfb_ctx_t)-2:0];
    c2_r[$bits(bgfb_ctx_t)-2:0] <= c2_nxt[$bits(bgfb_ctx_t)-2:0];
    c3_r[$bits(bgfb_ctx_t)-2:0] <= c3_nxt[$bits(bgfb_ctx_t)-2:0];
    c4_r[$bits(bgfb_ctx_t)-2:0] <= c4_nxt[$bits(bgfb_ctx_t)-2:0];
    sq_r <= sq_nxt;
    m1_r <= m1_nxt;
    u_r  <= u_nxt;
  end

  assign ctx = c4_r;
  assign u   = u_r;

endmodule

FILE: design/bgfb_tanh.sv
// ----------------------------------------------------------------------------
// bgfb_tanh
// tanh by table lookup and linear interpolation, two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgfb_tanh (
  input  logic                clk,
  input  logic                rst_n,
  input  bgfb_pkg::bgfb_ctx_t ctx_in,
  input  logic signed [15:0]  u,
  output bgfb_pkg::bgfb_ctx_t ctx,
  output logic signed [11:0]  t
);
  import bgfb_pkg::*;

  bgfb_ctx_t c5_r, c6_r;
  logic [31:0]            lo_r, lo_nxt;
  logic [31:0]            dif_r, dif_nxt;
  logic [TanhFbits-1:0]   fr_r, fr_nxt;
  logic                   big_r, big_nxt;
  logic                   neg_r, neg_nxt;
  logic signed [11:0]     t_r, t_nxt;
  logic [16:0]            m;
  logic [TanhAbits-1:0]   idx;
  logic [31:0]            hi;
  logic [31:0]            v;
  logic [63:0]            prod;
  logic [11:0]            mag;

  // Split |u| into table index and fraction, read both neighbors
  always_comb begin
    m       = u[15] ? 17'(-17'(u)) : 17'(u);
    idx     = m[TanhFbits +: TanhAbits];
    big_nxt = |m[16:TanhFbits+TanhAbits];
    fr_nxt  = m[TanhFbits-1:0];
    neg_nxt = u[15];
    lo_nxt  = TanhLut[idx];
    hi      = (idx == TanhAbits'(TanhDepth - 1)) ? Q30One : TanhLut[idx + 1'b1];
    dif_nxt = hi - lo_nxt;
  end

  // Interpolate, round to the output step, apply sign
  always_comb begin
    prod  = {32'd0, dif_r} * {{(64-TanhFbits){1'b0}}, fr_r};
    v     = big_r ? Q30One : lo_r + 32'(prod >> TanhFbits);
    mag   = 12'((v + (32'd1 << (29 - FracBits))) >> (30 - FracBits));
    t_nxt = neg_r ? -$signed(mag) : $signed(mag);
  end

  // Advance the valid bits (reset) and the data (no reset)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c5_r.vld <= 1'b0;
      c6_r.vld <= 1'b0;
    end else begin
      c5_r.vld <= ctx_in.vld;
      c6_r.vld <= c5_r.vld;
    end
    c5_r[$bits(bgfb_ctx_t)-2:0] <= ctx_in[$bits(bgfb_ctx_t)-2:0];
    c6_r[$bits(bgfb_ctx_t)-2:0] <= c5_r[$bits(bgfb_ctx_t)-2:0];
    lo_r  <= lo_nxt;
    dif_r <= dif_nxt;
    fr_r  <= fr_nxt;
    big_r <= big_nxt;
    neg_r <= neg_nxt;
    t_r   <= t_nxt;
  end

  assign ctx = c6_r;
  assign t   = t_r;

endmodule

FILE: design/bgfb_out.sv
// ----------------------------------------------------------------------------
// bgfb_out
// Forward product and backward derivative chain, five register stages,
// ending in the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgfb_out (
  input  logic                clk,
  input  logic                rst_n,
  input  bgfb_pkg::bgfb_ctx_t ctx_in,
  input  logic signed [11:0]  t,
  output logic                res_vld,
  output bgfb_pkg::bgfb_res_t res
);
  import bgfb_pkg::*;

  bgfb_ctx_t c7_r, c8_r, c9_r, c10_r;
  logic signed [16:0] fr7_r, fr8_r, fr9_r, fr10_r, fr7_nxt;
  logic signed [11:0] t7_r, t8_r, t9_r;
  logic [11:0]        tt_r, tt_nxt;
  logic signed [14:0] q_r, q_nxt;
  logic signed [17:0] q3_r, q3_nxt;
  logic signed [19:0] sum_r, sum_nxt;
  logic signed [14:0] q9_r;
  logic               vo_r;
  bgfb_res_t          res_r, res_nxt;
  logic signed [11:0] omt2;
  logic signed [31:0] x2m3;
  logic signed [23:0] rb;
  logic [16:0]        cl;

  // Forward product and t squared
  always_comb begin
    fr7_nxt = 17'(rmul(32'(ctx_in.x), OneQ + 32'(t), FracBits + 1));
    tt_nxt  = 12'(rmul(32'(t), 32'(t), FracBits));
  end

  // q = s*x*(1 - t^2)
  always_comb begin
    omt2  = 12'(OneQ) - $signed(tt_r);
    q_nxt = 15'(rmul(32'(c7_r.kxs), 32'(omt2), FracBits));
  end

  // q3 = q * 3*c*x^2
  always_comb begin
    x2m3   = (32'(c8_r.x2m) <<< 1) + 32'(c8_r.x2m);
    q3_nxt = 18'(rmul(32'(q_r), x2m3, FracBits));
  end

  // Sum the derivative terms
  always_comb begin
    sum_nxt = 20'(OneQ) + 20'(t9_r) + 20'(q9_r) + 20'(q3_r);
  end

  // Select the mode, scale the backward sum by the gradient, clamp
  always_comb begin
    rb = 24'(rmul(32'(c10_r.g), 32'(sum_r), FracBits + 1));
    cl = c10_r.mode ? clamp16(32'(rb)) : clamp16(32'(fr10_r));
    res_nxt.result_value = $signed(cl[15:0]);
    res_nxt.saturated    = cl[16] | c10_r.sat;
  end

  // Advance the valid bits (reset) and the data (no reset)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c7_r.vld  <= 1'b0;
      c8_r.vld  <= 1'b0;
      c9_r.vld  <= 1'b0;
      c10_r.vld <= 1'b0;
      vo_r      <= 1'b0;
    end else begin
      c7_r.vld  <= ctx_in.vld;
      c8_r.vld  <= c7_r.vld;
      c9_r.vld  <= c8_r.vld;
      c10_r.vld <= c9_r.vld;
      vo_r      <= c10_r.vld;
    end
    c7_r[$bits(bgfb_ctx_t)-2:0]  <= ctx_in[$bits(bgfb_ctx_t)-2:0];
    c8_r[$bits(bgfb_ctx_t)-2:0]  <= c7_r[$bits(bgfb_ctx_t)-2:0];
    c9_r[$bits(bgfb_ctx_t)-2:0]  <= c8_r[$bits(bgfb_ctx_t)-2:0];
    c10_r[$bits(bgfb_ctx_t)-2:0] <= c9_r[$bits(bgfb_ctx_t)-2:0];
    fr7_r  <= fr7_nxt;
    fr8_r  <= fr7_r;
    fr9_r  <= fr8_r;
    fr10_r <= fr9_r;
    t7_r   <= t;
    t8_r   <= t7_r;
    t9_r   <= t8_r;
    tt_r   <= tt_nxt;
    q_r    <= q_nxt;
    q9_r   <= q_r;
    q3_r   <= q3_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
  end

  assign res_vld = vo_r;
  assign res     = res_r;

endmodule

FILE: design/bgfb_checker.sv
// ----------------------------------------------------------------------------
// bgfb_checker
// Port-level checks of the GELU unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bias_gelu_forward_backward_assert.svh"

module bgfb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input bgfb_pkg::bgfb_req_t in_data,
  input logic                out_valid,
  input bgfb_pkg::bgfb_res_t out_data,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);
  import bgfb_pkg::*;

  // Every request yields a result after the fixed latency
  `BGFB_ASSERT(a_lat, (start && !busy) |-> ##PipeLatency out_valid, "result missing")
  // No result without a request that latency ago
  `BGFB_ASSERT(a_src, out_valid |-> $past(start && !busy, PipeLatency), "spurious result")
  // Busy never blocks requests out of reset
  `BGFB_NEVER(a_busy, busy && rst_n, "busy asserted")
  // A strobed result carries no unknown bits
  `BGFB_NEVER(a_known, out_valid && $isunknown(out_data), "unknown result bits")

endmodule

bind bias_gelu_forward_backward bgfb_checker u_bgfb_checker (.*);

FILE: verif/tb_bias_gelu_forward_backward.sv
// ----------------------------------------------------------------------------
// tb_bias_gelu_forward_backward
// Self-checking bench for the GELU unit. It drives forward and backward
// requests with random gaps, predicts each result from an independent Q5.10
// GELU computation, and checks every strobed result against the oldest
// prediction. bias_enable is switched between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bias_gelu_forward_backward;
  import bgfb_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int DrainCycles = PipeLatency + 4;
  localparam longint Q30 = 64'sd1 << 30;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  bgfb_req_t   in_data;
  logic        out_valid;
  bgfb_res_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bgfb_res_t   gelu_expected_q[$];
  longint      tanh_q30[TanhDepth];
  bit          bias_on;
  int          error_cnt;
  int          idle_cycles;
  bit          req_taken;

  bias_gelu_forward_backward i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded product a*b/2^k, ties away from zero on magnitudes
  function automatic longint round_mul(longint a, longint b, int k);
    bit neg;
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    r   = (ua * ub + (64'd1 << (k - 1))) >> k;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Fill the tanh table over [0,4) from a series for exp, then squaring
  task automatic fill_tanh_table();
    longint unsigned y, t1, t2, t3, t4, e;
    for (int i = 0; i < TanhDepth; i++) begin
      y  = ((64'(i) * 8) << 30) / TanhDepth / 256;
      t1 = (Q30 * y) >> 30;
      t2 = ((t1 * y) >> 30) / 2;
      t3 = ((t2 * y) >> 30) / 3;
      t4 = ((t3 * y) >> 30) / 4;
      e  = Q30 - t1 + t2 - t3 + t4;
      for (int k = 0; k < 8; k++) e = (e * e + (64'd1 << 29)) >> 30;
      tanh_q30[i] = ((Q30 - e) << 30) / (Q30 + e);
    end
  endtask

  // Interpolated tanh, returned in QF
  function automatic longint tanh_fixed(longint u);
    longint unsigned m, p, idx, fr, v, lo, hi, r;
    m   = (u < 0) ? -u : u;
    p   = m * TanhDepth;
    idx = p >> (FracBits + 2);
    fr  = p & ((64'd1 << (FracBits + 2)) - 1);
    if (idx >= TanhDepth) begin
      v = Q30;
    end else begin
      lo = tanh_q30[idx];
      hi = (idx + 1 < TanhDepth) ? tanh_q30[idx + 1] : Q30;
      v  = lo + (((hi - lo) * fr) >> (FracBits + 2));
    end
    r = (v + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
    return (u < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_data(longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // Expected GELU value or GELU gradient for one request
  function automatic bgfb_res_t gelu_predict(bgfb_req_t req, bit add_bias);
    bgfb_res_t res;
    bit sat;
    longint one, lim, x, xc, x2m, u, t, r, omt2, q, q3;
    one = 64'sd1 << FracBits;
    lim = 64'sd8 << FracBits;
    sat = 1'b0;
    x   = longint'(req.activation_in) + (add_bias ? longint'(req.bias_value) : 0);
    x   = clamp_data(x, sat);
    xc  = (x > lim) ? lim : ((x < -lim) ? -lim : x);
    x2m = round_mul(round_mul(xc, xc, FracBits), longint'(KCube), 30);
    u   = round_mul(xc + round_mul(xc, x2m, FracBits), longint'(KSqrt), 30);
    t   = tanh_fixed(u);
    if (!req.mode) begin
      r = round_mul(x, one + t, FracBits + 1);
    end else begin
      omt2 = one - round_mul(t, t, FracBits);
      q    = round_mul(round_mul(xc, longint'(KSqrt), 30), omt2, FracBits);
      q3   = round_mul(q, 3 * x2m, FracBits);
      r    = round_mul(longint'(req.grad_in), one + t + q + q3, FracBits + 1);
    end
    r = clamp_data(r, sat);
    res.result_value = r[DataWidth-1:0];
    res.saturated    = sat;
    return res;
  endfunction

  // Send one request after a random gap; start stays high across back-to-back requests
  task automatic send_req(bgfb_req_t req);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    req_taken = 1'b1;
    gelu_expected_q.push_back(gelu_predict(req, bias_on));
  endtask

  // Hold start low and wait for every expected result, then let the pipe settle
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    wait (gelu_expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write with a setup and an access phase; only called while the pipe is empty
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == RegBiasEnable) bias_on = data[0];
  endtask

  function automatic bgfb_req_t make_req(logic m, logic [15:0] a, logic [15:0] b,
                                         logic [15:0] g);
    bgfb_req_t req;
    req.mode          = m;
    req.activation_in = a;
    req.bias_value    = b;
    req.grad_in       = g;
    return req;
  endfunction

  // Random request, mostly in the curved region of gelu
  function automatic bgfb_req_t rand_req();
    bgfb_req_t req;
    req = make_req(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                   16'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      req.activation_in = 16'(int'($urandom_range(0, 12288)) - 6144);
      req.bias_value    = 16'(int'($urandom_range(0, 4096)) - 2048);
    end
    return req;
  endfunction

  // Field extremes, both modes, saturation and the flat tanh region
  task automatic test_directed();
    logic [15:0] vals[6];
    vals = '{16'h0000, 16'h7fff, 16'h8000, 16'h0400, 16'hfc00, 16'h1400};
    foreach (vals[i]) begin
      send_req(make_req(1'b0, vals[i], 16'h0000, 16'h7fff));
      send_req(make_req(1'b1, vals[i], 16'h0000, 16'h7fff));
    end
    send_req(make_req(1'b0, 16'h7fff, 16'h7fff, 16'h0000));
    send_req(make_req(1'b1, 16'h8000, 16'h8000, 16'h8000));
    send_req(make_req(1'b1, 16'h2000, 16'h0000, 16'h8000));
    send_req(make_req(1'b1, 16'h0200, 16'h0000, 16'h8000));
    send_req(make_req(1'b0, 16'hf000, 16'h0800, 16'h1234));
    send_req(make_req(1'b1, 16'hffff, 16'h0001, 16'hffff));
    drain_pipe();
  endtask

  // bias_enable off: bias ignored in both modes; also an unmapped write
  task automatic test_bias_off();
    cfg_write(RegBiasEnable, 32'h0);
    cfg_write(3'd4, 32'hffff_ffff);
    send_req(make_req(1'b0, 16'h7fff, 16'h7fff, 16'h0000));
    send_req(make_req(1'b1, 16'h0400, 16'h8000, 16'h7fff));
    for (int i = 0; i < 10; i++) send_req(rand_req());
    drain_pipe();
    cfg_write(RegBiasEnable, 32'hffff_fffe);
    for (int i = 0; i < 10; i++) send_req(rand_req());
    drain_pipe();
    cfg_write(RegBiasEnable, 32'h1);
  endtask

  // Random phases with bias_enable written to a random value between them
  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 100; i++) begin
        send_req(rand_req());
        if (i == 50 && ph == 3) drain_pipe();
      end
      drain_pipe();
      cfg_write(RegBiasEnable, {$urandom} & 32'h1);
    end
  endtask

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (gelu_expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_cnt++;
      end else begin
        bgfb_res_t exp_res;
        exp_res = gelu_expected_q.pop_front();
        if (out_data.result_value !== exp_res.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   exp_res.result_value, out_data.result_value);
          error_cnt++;
        end
        if (out_data.saturated !== exp_res.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time,
                   exp_res.saturated, out_data.saturated);
          error_cnt++;
        end
      end
    end
  end

  // Stop on a long stretch with no request taken and no result out
  always @(posedge clk) begin
    if (!rst_n || req_taken || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
    req_taken = 1'b0;
  end

  initial begin
    error_cnt   = 0;
    idle_cycles = 0;
    req_taken   = 1'b0;
    bias_on     = 1'b1;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fill_tanh_table();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_bias_off();
    test_random();
    drain_pipe();
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
